[src/cosp_pkg.sv]
// Shared types and codes for the CoAP option stream parser.
// Holds the input/output word structs and byte class codes; no dependencies.
`default_nettype none

package cosp_pkg;

    localparam int HEADER_BYTES = 4;

    localparam logic [2:0] CLS_HEADER  = 3'd0;
    localparam logic [2:0] CLS_TOKEN   = 3'd1;
    localparam logic [2:0] CLS_OPTHDR  = 3'd2;
    localparam logic [2:0] CLS_OPTEXT  = 3'd3;
    localparam logic [2:0] CLS_VALUE   = 3'd4;
    localparam logic [2:0] CLS_MARKER  = 3'd5;
    localparam logic [2:0] CLS_PAYLOAD = 3'd6;

    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIB_EXT1       = 4'd13;
    localparam logic [3:0]  NIB_EXT2       = 4'd14;
    localparam logic [15:0] EXT1_BIAS      = 16'd13;
    localparam logic [15:0] EXT2_BIAS      = 16'd269;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic        option_done;
        logic [15:0] option_number;
        logic [15:0] value_length;
        logic [7:0]  options_seen;
        logic        proxy_seen;
        logic [1:0]  version;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic        truncated;
        logic        last;
    } out_word_t;

endpackage

`default_nettype wire

[src/coap_option_stream_parser.sv]
// CoAP option stream parser top level: phase machine and result register.
// Depends on cosp_pkg for the word structs and byte class codes.
//
// Usage:
//   in_valid/in_ready/in_word carry one datagram byte per word, with
//   end_of_packet set on the final byte. out_valid/out_ready/out_word return
//   exactly one result word per input byte, in order.
//   cfg_we/cfg_wdata write the proxy option number (reset value 35); write
//   it only while no word is in flight.
// Output: the result of a byte appears on out_word in the cycle after it is
//   accepted. Throughput: one byte per cycle unless stalled, set by the single
//   result register; each byte updates the phase machine in one pass of logic.
// Stall: while out_valid is high and out_ready low the result holds and
//   in_ready drops; in_ready is high whenever the result register is empty
//   or being drained in the same cycle.
// Reset: rst_n clears the phase machine to the header phase, all per-datagram
//   state to zero and the proxy number to 35; no clearing pass is needed.
//   After each end_of_packet byte the per-datagram state returns to reset.
`default_nettype none

module coap_option_stream_parser #(
    parameter int COUNT_BITS = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  cosp_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  wire                  out_ready,
    output cosp_pkg::out_word_t  out_word,
    input  wire                  cfg_we,
    input  wire  [15:0]          cfg_wdata
);
    import cosp_pkg::*;

    localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [CW-1:0] CMAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TOKEN   = 3'd1;
    localparam logic [2:0] PH_OPTHDR  = 3'd2;
    localparam logic [2:0] PH_EXT     = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    function automatic logic [1:0] ext_bytes(input logic [3:0] nib);
        logic [1:0] n;
        n = 2'd0;
        if (nib == NIB_EXT1) n = 2'd1;
        else if (nib == NIB_EXT2) n = 2'd2;
        return n;
    endfunction

    function automatic logic [15:0] decode_field(input logic [3:0] nib,
                                                 input logic [15:0] ext);
        logic [15:0] v;
        v = {12'd0, nib};
        if (nib == NIB_EXT1) v = ext + EXT1_BIAS;
        else if (nib == NIB_EXT2) v = ext + EXT2_BIAS;
        return v;
    endfunction

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [15:0]   acc_reg, acc_next;
    logic [3:0]    dnib_reg, dnib_next;
    logic [3:0]    lnib_reg, lnib_next;
    logic [15:0]   ext_reg, ext_next;
    logic [15:0]   len_reg, len_next;
    logic [CW-1:0] tally_reg, tally_next;
    logic          proxy_reg, proxy_next;
    logic [31:0]   hdr_reg, hdr_next;
    logic [15:0]   proxy_num_reg;
    logic          out_valid_reg;
    out_word_t     out_word_reg, out_word_next;

    logic          accept;
    logic [7:0]    b;
    logic          eop;
    logic [2:0]    cls;
    logic          finish;
    logic [2:0]    idx_inc;
    logic [2:0]    ext_total;
    logic [15:0]   fin_acc;
    logic [15:0]   fin_len;
    logic          trunc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign b   = in_word.data_byte;
    assign eop = in_word.end_of_packet;

    assign ext_total = {1'b0, ext_bytes(dnib_reg)} + {1'b0, ext_bytes(lnib_reg)};
    assign idx_inc   = {1'b0, cnt_reg[1:0]} + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        dnib_next  = dnib_reg;
        lnib_next  = lnib_reg;
        ext_next   = ext_reg;
        len_next   = len_reg;
        tally_next = tally_reg;
        proxy_next = proxy_reg;
        hdr_next   = hdr_reg;
        cls        = CLS_PAYLOAD;
        finish     = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                cls = CLS_HEADER;
                case (cnt_reg[1:0])
                    2'd0:    hdr_next[31:24] = b;
                    2'd1:    hdr_next[23:16] = b;
                    2'd2:    hdr_next[15:8]  = b;
                    default: hdr_next[7:0]   = b;
                endcase
                if (idx_inc >= 3'(HEADER_BYTES))
                begin
                    if (hdr_next[27:24] != 4'd0)
                    begin
                        phase_next = PH_TOKEN;
                        cnt_next   = {12'd0, hdr_next[27:24]};
                    end
                    else
                    begin
                        phase_next = PH_OPTHDR;
                        cnt_next   = 16'd0;
                    end
                end
                else
                begin
                    cnt_next = {13'd0, idx_inc};
                end
            end
            PH_TOKEN, PH_VALUE:
            begin
                cls = (phase_reg == PH_TOKEN) ? CLS_TOKEN : CLS_VALUE;
                if (cnt_reg != 16'd0) cnt_next = cnt_reg - 16'd1;
                if (cnt_next == 16'd0) phase_next = PH_OPTHDR;
            end
            PH_OPTHDR:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    cls        = CLS_MARKER;
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    cls       = CLS_OPTHDR;
                    dnib_next = b[7:4];
                    lnib_next = b[3:0];
                    ext_next  = 16'd0;
                    len_next  = (ext_bytes(b[3:0]) != 2'd0) ? 16'd0 : {12'd0, b[3:0]};
                    if (ext_bytes(b[7:4]) == 2'd0 && ext_bytes(b[3:0]) == 2'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_EXT;
                        cnt_next   = 16'd0;
                    end
                end
            end
            PH_EXT:
            begin
                cls = CLS_OPTEXT;
                // Delta extension bytes come first, then length extension bytes.
                if (cnt_reg[1:0] < ext_bytes(dnib_reg))
                    ext_next = {ext_reg[7:0], b};
                else
                    len_next = {len_reg[7:0], b};
                if (idx_inc >= ext_total)
                    finish = 1'b1;
                else
                    cnt_next = {13'd0, idx_inc};
            end
            default:
            begin
                cls        = CLS_PAYLOAD;
                phase_next = PH_PAYLOAD;
            end
        endcase

        // Decoded option from the nibbles and extension bytes as they stand after this byte.
        fin_acc = acc_reg + decode_field(dnib_next, ext_next);
        fin_len = decode_field(lnib_next, len_next);

        if (finish)
        begin
            acc_next = fin_acc;
            len_next = fin_len;
            if (tally_reg != CMAX) tally_next = tally_reg + CW'(1);
            if (fin_acc == proxy_num_reg) proxy_next = 1'b1;
            if (fin_len != 16'd0)
            begin
                phase_next = PH_VALUE;
                cnt_next   = fin_len;
            end
            else
            begin
                phase_next = PH_OPTHDR;
                cnt_next   = 16'd0;
            end
        end

        trunc = eop && (phase_next == PH_HEADER || phase_next == PH_TOKEN ||
                        phase_next == PH_EXT || phase_next == PH_VALUE);

        out_word_next.byte_class    = cls;
        out_word_next.option_done   = finish;
        out_word_next.option_number = acc_next;
        out_word_next.value_length  = len_next;
        out_word_next.options_seen  = tally_next[7:0];
        out_word_next.proxy_seen    = proxy_next;
        out_word_next.version       = hdr_next[31:30];
        out_word_next.token_length  = hdr_next[27:24];
        out_word_next.code          = hdr_next[23:16];
        out_word_next.message_id    = hdr_next[15:0];
        out_word_next.truncated     = trunc;
        out_word_next.last          = eop;

        // Drop all per-datagram state after the final byte.
        if (eop)
        begin
            phase_next = PH_HEADER;
            cnt_next   = 16'd0;
            acc_next   = 16'd0;
            dnib_next  = 4'd0;
            lnib_next  = 4'd0;
            ext_next   = 16'd0;
            len_next   = 16'd0;
            tally_next = '0;
            proxy_next = 1'b0;
            hdr_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            cnt_reg       <= 16'd0;
            acc_reg       <= 16'd0;
            dnib_reg      <= 4'd0;
            lnib_reg      <= 4'd0;
            ext_reg       <= 16'd0;
            len_reg       <= 16'd0;
            tally_reg     <= '0;
            proxy_reg     <= 1'b0;
            hdr_reg       <= 32'd0;
            proxy_num_reg <= 16'd35;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) proxy_num_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                dnib_reg  <= dnib_next;
                lnib_reg  <= lnib_next;
                ext_reg   <= ext_next;
                len_reg   <= len_next;
                tally_reg <= tally_next;
                proxy_reg <= proxy_next;
                hdr_reg   <= hdr_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

[src/cosp_checker.sv]
// Port-level checks for the CoAP option stream parser, bound to the top level.
// Depends on cosp_pkg for the word struct and byte class codes.
`default_nettype none

module cosp_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input cosp_pkg::out_word_t out_word
);
    import cosp_pkg::*;

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");

    // Stall input only behind a stalled result.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // Finish options only on option header or extension bytes, with a nonzero count.
    a_done_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.option_done |->
            (out_word.byte_class == CLS_OPTHDR || out_word.byte_class == CLS_OPTEXT)
            && out_word.options_seen != 8'd0)
        else $error("option finished on wrong byte class");

    // Flag truncation only on the final byte.
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.truncated |-> out_word.last)
        else $error("truncated set on a non-final byte");

    // Advance the result register by one word per accepted input.
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted byte produced no result");

endmodule

bind coap_option_stream_parser cosp_checker u_cosp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

`default_nettype wire
